@@ rtl/uart_rb_pkg.sv @@
// ----------------------------------------------------------------------------
// UART ring buffer package
// Shared types and codes for the UART ring buffers with XON/XOFF flow control.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

    // Event codes carried in the action field
    localparam logic [1:0] ACT_LINE_BYTE = 2'd0;
    localparam logic [1:0] ACT_TX_DONE   = 2'd1;
    localparam logic [1:0] ACT_HOST_SEND = 2'd2;
    localparam logic [1:0] ACT_HOST_RECV = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TX_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RX_EMPTY = 2'd2;

    // Configuration port
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 8;

    localparam logic [CFG_AW-1:0] CFG_HANDSHAKE = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_XON       = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_XOFF      = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_FRAMING   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_BREAK     = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_OVERRUN   = 3'd6;

    // Configuration reset values
    localparam logic [5:0] THRESHOLD_RST = 6'd8;
    localparam logic [7:0] XON_RST       = 8'd17;
    localparam logic [7:0] XOFF_RST      = 8'd19;

    // One input event
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] line_byte;
        logic       framing_error;
        logic       break_seen;
        logic       overrun_error;
        logic [7:0] host_byte;
    } t_in_item;

    // One result
    typedef struct packed {
        logic       line_send_valid;
        logic [7:0] line_send_byte;
        logic       host_data_valid;
        logic [7:0] host_data_byte;
        logic [1:0] status;
    } t_out_item;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } t_cmd;

endpackage

@@ rtl/uart_rb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module uart_rb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/uart_rb_ctrl.sv @@
// ----------------------------------------------------------------------------
// UART ring buffer controller
// Sequences one event at a time: take, execute, fetch memory data, deliver.
// ----------------------------------------------------------------------------
module uart_rb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output uart_rb_pkg::t_cmd  o_cmd
);

    uart_rb_pkg::t_state r_state;
    uart_rb_pkg::t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            uart_rb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = uart_rb_pkg::ST_EXEC;
                end
            end
            uart_rb_pkg::ST_EXEC:  n_state = uart_rb_pkg::ST_FETCH;
            uart_rb_pkg::ST_FETCH: n_state = uart_rb_pkg::ST_OUT;
            uart_rb_pkg::ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = uart_rb_pkg::ST_IDLE;
                end
            end
            default: n_state = uart_rb_pkg::ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uart_rb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs and commands
    always_comb begin
        o_in_stall       = 1'b1;
        o_out_valid      = 1'b0;
        o_cmd.capture    = 1'b0;
        o_cmd.exec       = 1'b0;
        o_cmd.load_out   = 1'b0;
        case (r_state)
            uart_rb_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            uart_rb_pkg::ST_EXEC:  o_cmd.exec     = 1'b1;
            uart_rb_pkg::ST_FETCH: o_cmd.load_out = 1'b1;
            uart_rb_pkg::ST_OUT:   o_out_valid    = 1'b1;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

@@ rtl/uart_rb_dpath.sv @@
// ----------------------------------------------------------------------------
// UART ring buffer datapath
// Configuration, ring pointers, flow control flags, ring memories and result.
// ----------------------------------------------------------------------------
module uart_rb_dpath #(
    parameter int unsigned RX_DEPTH = 64,
    parameter int unsigned TX_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  uart_rb_pkg::t_cmd                   i_cmd,
    input  uart_rb_pkg::t_in_item               i_in_data,
    input  logic                                i_cfg_we,
    input  logic [uart_rb_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [uart_rb_pkg::CFG_DW-1:0]      i_cfg_wdata,
    output uart_rb_pkg::t_out_item              o_out_data
);

    localparam int unsigned RX_AW = $clog2(RX_DEPTH);
    localparam int unsigned TX_AW = $clog2(TX_DEPTH);
    localparam int unsigned RX_FW = $clog2(RX_DEPTH + 1);
    localparam int unsigned CMP_W = (RX_FW > 7) ? RX_FW : 7;
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    // Configuration registers
    logic       r_hs;
    logic [5:0] r_thr;
    logic [7:0] r_xon;
    logic [7:0] r_xoff;
    logic [7:0] r_fe_code;
    logic [7:0] r_br_code;
    logic [7:0] r_oe_code;

    // Ring and flow state
    logic [RX_AW-1:0] r_rx_head, n_rx_head;
    logic [RX_AW-1:0] r_rx_tail, n_rx_tail;
    logic [TX_AW-1:0] r_tx_head, n_tx_head;
    logic [TX_AW-1:0] r_tx_tail, n_tx_tail;
    logic             r_paused,  n_paused;
    logic             r_halted,  n_halted;
    logic             r_tx_idle, n_tx_idle;

    // Event and partial result
    uart_rb_pkg::t_in_item  r_item;
    logic                   r_send_v,    n_send_v;
    logic                   r_send_ram,  n_send_ram;
    logic [7:0]             r_send_byte, n_send_byte;
    logic                   r_host_v,    n_host_v;
    logic [1:0]             r_status,    n_status;
    uart_rb_pkg::t_out_item r_out;

    // Memory ports
    logic             rx_we;
    logic [RX_AW-1:0] rx_waddr;
    logic [RX_AW-1:0] rx_raddr;
    logic [7:0]       rx_rdata;
    logic             tx_we;
    logic [TX_AW-1:0] tx_waddr;
    logic [TX_AW-1:0] tx_raddr;
    logic [7:0]       tx_rdata;

    // Derived values
    logic [7:0]       rx_char;
    logic [RX_AW-1:0] rx_head_inc;
    logic [RX_AW-1:0] rx_tail_inc;
    logic [TX_AW-1:0] tx_head_inc;
    logic [TX_AW-1:0] tx_tail_inc;
    logic [CMP_W-1:0] free_now;
    logic [CMP_W-1:0] free_after_read;
    logic [CMP_W-1:0] thr_ext;
    logic [CMP_W-1:0] thr_plus2;
    logic             rx_room;

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        return (p == RX_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
        return (p == TX_LAST) ? '0 : p + 1'b1;
    endfunction

    // Free receive slots for a given head and tail
    function automatic logic [CMP_W-1:0] rx_free(input logic [RX_AW-1:0] head,
                                                 input logic [RX_AW-1:0] tail);
        logic [RX_FW-1:0] f;
        if (head >= tail) begin
            f = RX_FW'(RX_DEPTH) + RX_FW'(tail) - RX_FW'(head);
        end else begin
            f = RX_FW'(tail) - RX_FW'(head);
        end
        return CMP_W'(f);
    endfunction

    // Substitute the error code, overrun over break over framing
    always_comb begin
        rx_char = r_item.line_byte;
        if (r_item.framing_error) begin
            rx_char = r_fe_code;
        end
        if (r_item.break_seen) begin
            rx_char = r_br_code;
        end
        if (r_item.overrun_error) begin
            rx_char = r_oe_code;
        end
    end

    assign rx_head_inc     = rx_inc(r_rx_head);
    assign rx_tail_inc     = rx_inc(r_rx_tail);
    assign tx_head_inc     = tx_inc(r_tx_head);
    assign tx_tail_inc     = tx_inc(r_tx_tail);
    assign free_now        = rx_free(r_rx_head, r_rx_tail);
    assign free_after_read = rx_free(r_rx_head, rx_tail_inc);
    assign thr_ext         = CMP_W'(r_thr);
    assign thr_plus2       = CMP_W'(r_thr) + CMP_W'(2);
    assign rx_room         = free_now > CMP_W'(1);

    // Execute one event
    always_comb begin
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_paused    = r_paused;
        n_halted    = r_halted;
        n_tx_idle   = r_tx_idle;
        n_send_v    = 1'b0;
        n_send_ram  = 1'b0;
        n_send_byte = 8'd0;
        n_host_v    = 1'b0;
        n_status    = uart_rb_pkg::STATUS_OK;
        rx_we       = 1'b0;
        rx_waddr    = rx_head_inc;
        rx_raddr    = rx_tail_inc;
        tx_we       = 1'b0;
        tx_waddr    = tx_head_inc;
        tx_raddr    = tx_tail_inc;
        case (r_item.action)
            uart_rb_pkg::ACT_LINE_BYTE: begin
                if (!r_hs) begin
                    if (free_now > thr_ext && rx_room) begin
                        rx_we     = 1'b1;
                        n_rx_head = rx_head_inc;
                    end
                end else if (rx_char == r_xoff) begin
                    n_halted = 1'b1;
                end else if (rx_char == r_xon) begin
                    n_halted = 1'b0;
                    if (r_tx_idle && r_tx_tail != r_tx_head) begin
                        n_tx_tail  = tx_tail_inc;
                        n_tx_idle  = 1'b0;
                        n_send_v   = 1'b1;
                        n_send_ram = 1'b1;
                    end
                end else begin
                    if (free_now <= thr_ext) begin
                        n_paused    = 1'b1;
                        n_tx_idle   = 1'b0;
                        n_send_v    = 1'b1;
                        n_send_byte = r_xoff;
                    end
                    if (rx_room) begin
                        rx_we     = 1'b1;
                        n_rx_head = rx_head_inc;
                    end
                end
            end
            uart_rb_pkg::ACT_TX_DONE: begin
                if (!r_halted && r_tx_tail != r_tx_head) begin
                    n_tx_tail  = tx_tail_inc;
                    n_send_v   = 1'b1;
                    n_send_ram = 1'b1;
                end else begin
                    n_tx_idle = 1'b1;
                end
            end
            uart_rb_pkg::ACT_HOST_SEND: begin
                if (tx_head_inc == r_tx_tail) begin
                    n_status = uart_rb_pkg::STATUS_TX_FULL;
                end else begin
                    tx_we     = 1'b1;
                    n_tx_head = tx_head_inc;
                    if (r_tx_idle && !r_halted) begin
                        n_tx_idle = 1'b0;
                        n_tx_tail = tx_tail_inc;
                        n_send_v  = 1'b1;
                        // Ring was empty: forward the byte being written
                        if (r_tx_tail == r_tx_head) begin
                            n_send_byte = r_item.host_byte;
                        end else begin
                            n_send_ram = 1'b1;
                        end
                    end
                end
            end
            uart_rb_pkg::ACT_HOST_RECV: begin
                if (r_rx_head == r_rx_tail) begin
                    n_status = uart_rb_pkg::STATUS_RX_EMPTY;
                end else begin
                    n_rx_tail = rx_tail_inc;
                    n_host_v  = 1'b1;
                    if (r_hs && r_paused && free_after_read > thr_plus2) begin
                        n_paused    = 1'b0;
                        n_tx_idle   = 1'b0;
                        n_send_v    = 1'b1;
                        n_send_byte = r_xon;
                    end
                end
            end
            default: n_status = uart_rb_pkg::STATUS_OK;
        endcase
        if (!i_cmd.exec) begin
            rx_we = 1'b0;
            tx_we = 1'b0;
        end
    end

    // Control state: configuration, pointers and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs      <= 1'b0;
            r_thr     <= uart_rb_pkg::THRESHOLD_RST;
            r_xon     <= uart_rb_pkg::XON_RST;
            r_xoff    <= uart_rb_pkg::XOFF_RST;
            r_fe_code <= 8'd0;
            r_br_code <= 8'd0;
            r_oe_code <= 8'd0;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_paused  <= 1'b0;
            r_halted  <= 1'b0;
            r_tx_idle <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    uart_rb_pkg::CFG_HANDSHAKE: r_hs      <= i_cfg_wdata[0];
                    uart_rb_pkg::CFG_THRESHOLD: r_thr     <= i_cfg_wdata[5:0];
                    uart_rb_pkg::CFG_XON:       r_xon     <= i_cfg_wdata;
                    uart_rb_pkg::CFG_XOFF:      r_xoff    <= i_cfg_wdata;
                    uart_rb_pkg::CFG_FRAMING:   r_fe_code <= i_cfg_wdata;
                    uart_rb_pkg::CFG_BREAK:     r_br_code <= i_cfg_wdata;
                    uart_rb_pkg::CFG_OVERRUN:   r_oe_code <= i_cfg_wdata;
                    default: r_hs <= r_hs;
                endcase
            end
            if (i_cmd.exec) begin
                r_rx_head <= n_rx_head;
                r_rx_tail <= n_rx_tail;
                r_tx_head <= n_tx_head;
                r_tx_tail <= n_tx_tail;
                r_paused  <= n_paused;
                r_halted  <= n_halted;
                r_tx_idle <= n_tx_idle;
            end
        end
    end

    // Payload: event, partial result and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_send_v    <= n_send_v;
            r_send_ram  <= n_send_ram;
            r_send_byte <= n_send_byte;
            r_host_v    <= n_host_v;
            r_status    <= n_status;
        end
        if (i_cmd.load_out) begin
            r_out.line_send_valid <= r_send_v;
            r_out.line_send_byte  <= r_send_ram ? tx_rdata : r_send_byte;
            r_out.host_data_valid <= r_host_v;
            r_out.host_data_byte  <= r_host_v ? rx_rdata : 8'd0;
            r_out.status          <= r_status;
        end
    end

    assign o_out_data = r_out;

    // Ring memories
    uart_rb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_char),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    uart_rb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (r_item.host_byte),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

endmodule

@@ rtl/uart_rb_core.sv @@
// ----------------------------------------------------------------------------
// UART ring buffers with XON/XOFF flow control
// Receive and transmit rings between a UART line and a host, one event at
// a time.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------
//  input   | i_in_valid  | o_in_stall  | i_in_data  (t_in_item)
//  output  | o_out_valid | i_out_stall | o_out_data (t_out_item)
//  config  | i_cfg_we    | -           | i_cfg_addr, i_cfg_wdata
//
// Each event passes through take, execute (pointer update and memory
// write/read address), memory read data and deliver. The registered read
// of the ring memories separates the execute and memory read data steps.
// Reset is synchronous, active low; the rings come up empty, no clearing pass.
// A stalled result holds the block; no new event is taken until it transfers.
// ----------------------------------------------------------------------------
module uart_ring_buffers_xon_xoff_unit #(
    parameter int unsigned RX_DEPTH = 64,
    parameter int unsigned TX_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  uart_rb_pkg::t_in_item           i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output uart_rb_pkg::t_out_item          o_out_data,
    input  logic                            i_cfg_we,
    input  logic [uart_rb_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [uart_rb_pkg::CFG_DW-1:0]  i_cfg_wdata
);

    uart_rb_pkg::t_cmd cmd;

    // Sequencer
    uart_rb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Rings, flags and result
    uart_rb_dpath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/tb_uart_ring_buffers_xon_xoff_unit.sv @@
// ----------------------------------------------------------------------------
// Testbench for the UART ring buffers with XON/XOFF flow control
// Drives line, transmit-done, host send and host receive events through the
// valid/stall input channel and checks every result, mostly against an
// in-bench model of both rings and the flow-control flags. A short scripted
// table covers the corner cases; weighted random traffic then fills and
// drains both rings under several register settings, with random idle and stall.
// ----------------------------------------------------------------------------
module tb_uart_ring_buffers_xon_xoff_unit;

    localparam int          RING_DEPTH    = 64;
    localparam int          NUM_PHASES    = 8;
    localparam int          PHASE_ITEMS   = 110;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // Index past the last register; writes to it must change nothing
    localparam logic [uart_rb_pkg::CFG_AW-1:0] CFG_UNUSED = 3'd7;

    // Traffic shapes for random segments
    typedef enum int {
        MIX_RX_FILL,
        MIX_RX_DRAIN,
        MIX_TX_FILL,
        MIX_TX_DRAIN,
        MIX_ANY
    } t_mix;

    // One row of the scripted opening sequence
    typedef struct {
        bit                             is_reg;
        logic [uart_rb_pkg::CFG_AW-1:0] reg_idx;
        logic [7:0]                     reg_val;
        uart_rb_pkg::t_in_item          ev;
        bit                             has_want;
        uart_rb_pkg::t_out_item         want;
    } t_script_row;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    uart_rb_pkg::t_in_item          i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    uart_rb_pkg::t_out_item         o_out_data;
    logic                           i_cfg_we    = 1'b0;
    logic [uart_rb_pkg::CFG_AW-1:0] i_cfg_addr  = '0;
    logic [uart_rb_pkg::CFG_DW-1:0] i_cfg_wdata = '0;

    // Register copy
    logic       handshake_on   = 1'b0;
    logic [5:0] flow_threshold = uart_rb_pkg::THRESHOLD_RST;
    logic [7:0] xon_code       = uart_rb_pkg::XON_RST;
    logic [7:0] xoff_code      = uart_rb_pkg::XOFF_RST;
    logic [7:0] framing_code   = 8'h00;
    logic [7:0] break_code     = 8'h00;
    logic [7:0] overrun_code   = 8'h00;

    // Ring and flow state
    logic [7:0] rx_ring [RING_DEPTH];
    logic [7:0] tx_ring [RING_DEPTH];
    logic [5:0] rx_head = '0;
    logic [5:0] rx_tail = '0;
    logic [5:0] tx_head = '0;
    logic [5:0] tx_tail = '0;
    bit         remote_stopped = 1'b0;
    bit         tx_halted      = 1'b0;
    bit         tx_idle        = 1'b1;

    uart_rb_pkg::t_out_item ring_replies [$];
    t_script_row            script [$];
    int                     mismatch_count = 0;
    bit                     calm = 1'b0;
    int unsigned            cycle_count;

    uart_ring_buffers_xon_xoff_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Ring model
    // ------------------------------------------------------------------
    function automatic int rx_space();
        if (rx_head >= rx_tail) begin
            return RING_DEPTH + int'(rx_tail) - int'(rx_head);
        end
        return int'(rx_tail) - int'(rx_head);
    endfunction

    // Store unless that would fill the last slot
    function automatic void rx_store(logic [7:0] b);
        if (rx_space() > 1) begin
            rx_head = 6'(rx_head + 1'b1);
            rx_ring[rx_head] = b;
        end
    endfunction

    // Advance the transmit tail when data is waiting and sending is allowed
    function automatic bit tx_take(output logic [7:0] b);
        b = '0;
        if (!tx_halted && tx_tail != tx_head) begin
            tx_tail = 6'(tx_tail + 1'b1);
            b = tx_ring[tx_tail];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void apply_reg(logic [uart_rb_pkg::CFG_AW-1:0] idx,
                                      logic [7:0] val);
        case (idx)
            uart_rb_pkg::CFG_HANDSHAKE: handshake_on   = val[0];
            uart_rb_pkg::CFG_THRESHOLD: flow_threshold = val[5:0];
            uart_rb_pkg::CFG_XON:       xon_code       = val;
            uart_rb_pkg::CFG_XOFF:      xoff_code      = val;
            uart_rb_pkg::CFG_FRAMING:   framing_code   = val;
            uart_rb_pkg::CFG_BREAK:     break_code     = val;
            uart_rb_pkg::CFG_OVERRUN:   overrun_code   = val;
            default: ;
        endcase
    endfunction

    function automatic uart_rb_pkg::t_out_item ring_event(uart_rb_pkg::t_in_item ev);
        uart_rb_pkg::t_out_item res;
        logic [7:0]             ch;
        logic [7:0]             b;
        res = '0;
        res.status = uart_rb_pkg::STATUS_OK;
        case (ev.action)
            uart_rb_pkg::ACT_LINE_BYTE: begin
                // Substitute on line errors; overrun wins, then break
                ch = ev.line_byte;
                if (ev.framing_error) ch = framing_code;
                if (ev.break_seen)    ch = break_code;
                if (ev.overrun_error) ch = overrun_code;
                if (!handshake_on) begin
                    if (rx_space() > int'(flow_threshold)) rx_store(ch);
                end else if (ch == xoff_code) begin
                    tx_halted = 1'b1;
                end else if (ch == xon_code) begin
                    tx_halted = 1'b0;
                    if (tx_idle && tx_take(b)) begin
                        tx_idle = 1'b0;
                        res.line_send_valid = 1'b1;
                        res.line_send_byte  = b;
                    end
                end else begin
                    if (rx_space() <= int'(flow_threshold)) begin
                        remote_stopped = 1'b1;
                        tx_idle = 1'b0;
                        res.line_send_valid = 1'b1;
                        res.line_send_byte  = xoff_code;
                    end
                    rx_store(ch);
                end
            end
            uart_rb_pkg::ACT_TX_DONE: begin
                if (tx_take(b)) begin
                    res.line_send_valid = 1'b1;
                    res.line_send_byte  = b;
                end else begin
                    tx_idle = 1'b1;
                end
            end
            uart_rb_pkg::ACT_HOST_SEND: begin
                if (6'(tx_head + 1'b1) == tx_tail) begin
                    res.status = uart_rb_pkg::STATUS_TX_FULL;
                end else begin
                    tx_head = 6'(tx_head + 1'b1);
                    tx_ring[tx_head] = ev.host_byte;
                    if (tx_idle && !tx_halted) begin
                        tx_idle = 1'b0;
                        tx_tail = 6'(tx_tail + 1'b1);
                        res.line_send_valid = 1'b1;
                        res.line_send_byte  = tx_ring[tx_tail];
                    end
                end
            end
            default: begin
                if (rx_head == rx_tail) begin
                    res.status = uart_rb_pkg::STATUS_RX_EMPTY;
                end else begin
                    rx_tail = 6'(rx_tail + 1'b1);
                    // Resume the remote once enough room is back
                    if (handshake_on && remote_stopped &&
                        rx_space() > int'(flow_threshold) + 2) begin
                        remote_stopped = 1'b0;
                        tx_idle = 1'b0;
                        res.line_send_valid = 1'b1;
                        res.line_send_byte  = xon_code;
                    end
                    res.host_data_valid = 1'b1;
                    res.host_data_byte  = rx_ring[rx_tail];
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic uart_rb_pkg::t_in_item mk_ev(logic [1:0] act, logic [7:0] lb,
                                                    logic fe, logic br, logic oe,
                                                    logic [7:0] hb);
        uart_rb_pkg::t_in_item ev;
        ev.action        = act;
        ev.line_byte     = lb;
        ev.framing_error = fe;
        ev.break_seen    = br;
        ev.overrun_error = oe;
        ev.host_byte     = hb;
        return ev;
    endfunction

    function automatic uart_rb_pkg::t_out_item mk_out(logic sv, logic [7:0] sb, logic hv,
                                                      logic [7:0] hb, logic [1:0] st);
        uart_rb_pkg::t_out_item r;
        r.line_send_valid = sv;
        r.line_send_byte  = sb;
        r.host_data_valid = hv;
        r.host_data_byte  = hb;
        r.status          = st;
        return r;
    endfunction

    function automatic void add_reg(logic [uart_rb_pkg::CFG_AW-1:0] idx, logic [7:0] val);
        t_script_row row;
        row = '{default: '0};
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        script.push_back(row);
    endfunction

    function automatic void add_ev(uart_rb_pkg::t_in_item ev, bit has_want,
                                   uart_rb_pkg::t_out_item want);
        t_script_row row;
        row = '{default: '0};
        row.ev       = ev;
        row.has_want = has_want;
        row.want     = want;
        script.push_back(row);
    endfunction

    function automatic uart_rb_pkg::t_in_item pick_event(t_mix m);
        uart_rb_pkg::t_in_item ev;
        int                    r;
        int                    k;
        ev.line_byte     = 8'($urandom_range(0, 255));
        ev.host_byte     = 8'($urandom_range(0, 255));
        ev.framing_error = 1'($urandom_range(0, 1));
        ev.break_seen    = 1'($urandom_range(0, 1));
        ev.overrun_error = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        case (m)
            MIX_RX_FILL: begin
                ev.action = (r < 85) ? uart_rb_pkg::ACT_LINE_BYTE :
                            (r < 90) ? uart_rb_pkg::ACT_HOST_RECV :
                            (r < 95) ? uart_rb_pkg::ACT_HOST_SEND : uart_rb_pkg::ACT_TX_DONE;
            end
            MIX_RX_DRAIN: begin
                ev.action = (r < 70) ? uart_rb_pkg::ACT_HOST_RECV :
                            (r < 80) ? uart_rb_pkg::ACT_LINE_BYTE :
                            (r < 90) ? uart_rb_pkg::ACT_HOST_SEND : uart_rb_pkg::ACT_TX_DONE;
            end
            MIX_TX_FILL: begin
                ev.action = (r < 85) ? uart_rb_pkg::ACT_HOST_SEND :
                            (r < 92) ? uart_rb_pkg::ACT_TX_DONE :
                            (r < 96) ? uart_rb_pkg::ACT_LINE_BYTE : uart_rb_pkg::ACT_HOST_RECV;
            end
            MIX_TX_DRAIN: begin
                ev.action = (r < 60) ? uart_rb_pkg::ACT_TX_DONE :
                            (r < 75) ? uart_rb_pkg::ACT_HOST_SEND :
                            (r < 90) ? uart_rb_pkg::ACT_LINE_BYTE : uart_rb_pkg::ACT_HOST_RECV;
            end
            default: ev.action = 2'($urandom_range(0, 3));
        endcase
        // Mostly clean bytes, some flow characters, some line errors
        k = $urandom_range(0, 99);
        if (k < 8) begin
            ev.line_byte = xoff_code;
        end else if (k < 16) begin
            ev.line_byte = xon_code;
        end
        if (k < 16 || k >= 28) begin
            ev.framing_error = 1'b0;
            ev.break_seen    = 1'b0;
            ev.overrun_error = 1'b0;
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic drive_item(input uart_rb_pkg::t_in_item ev, input bit has_want,
                              input uart_rb_pkg::t_out_item want);
        int                     gap;
        uart_rb_pkg::t_out_item pred;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (o_in_stall);
        pred = ring_event(ev);
        ring_replies.push_back(has_want ? want : pred);
    endtask

    // Drop valid and wait until every result has transferred
    task automatic settle();
        i_in_valid <= 1'b0;
        while (ring_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Hold the write enable; the caller lowers it after the last write
    task automatic write_reg(input logic [uart_rb_pkg::CFG_AW-1:0] idx,
                             input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall per transfer, then compare
    // ------------------------------------------------------------------
    initial begin
        int n;
        forever begin
            n = calm ? 0 : $urandom_range(0, 19);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    function automatic void check_reply(uart_rb_pkg::t_out_item got);
        uart_rb_pkg::t_out_item want;
        if (ring_replies.size() == 0) begin
            $error("result with none outstanding: %h", got);
            mismatch_count++;
            return;
        end
        want = ring_replies.pop_front();
        if (got.line_send_valid !== want.line_send_valid) begin
            $error("line_send_valid expected %0d actual %0d",
                   want.line_send_valid, got.line_send_valid);
            mismatch_count++;
        end
        if (got.line_send_byte !== want.line_send_byte) begin
            $error("line_send_byte expected %02h actual %02h",
                   want.line_send_byte, got.line_send_byte);
            mismatch_count++;
        end
        if (got.host_data_valid !== want.host_data_valid) begin
            $error("host_data_valid expected %0d actual %0d",
                   want.host_data_valid, got.host_data_valid);
            mismatch_count++;
        end
        if (got.host_data_byte !== want.host_data_byte) begin
            $error("host_data_byte expected %02h actual %02h",
                   want.host_data_byte, got.host_data_byte);
            mismatch_count++;
        end
        if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_reply(o_out_data);
    end

    // Watchdog
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("uart_ring_buffers_xon_xoff_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        bit                     in_reg_run;
        int                     done;
        int                     seg_len;
        t_mix                   seg_mix;
        logic [5:0]             thr;
        logic [7:0]             codes [5];
        logic                   hs;
        uart_rb_pkg::t_out_item none;

        none = mk_out(1'b0, 8'h00, 1'b0, 8'h00, uart_rb_pkg::STATUS_OK);

        // Reset defaults: no handshake, threshold 8, error codes zero
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_RECV, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF), 1'b1,
               mk_out(1'b0, 8'h00, 1'b0, 8'h00, uart_rb_pkg::STATUS_RX_EMPTY));
        add_ev(mk_ev(uart_rb_pkg::ACT_TX_DONE,   8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_SEND, 8'h00, 1'b0, 1'b0, 1'b0, 8'hFF), 1'b1,
               mk_out(1'b1, 8'hFF, 1'b0, 8'h00, uart_rb_pkg::STATUS_OK));
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_SEND, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_TX_DONE,   8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
               mk_out(1'b1, 8'h00, 1'b0, 8'h00, uart_rb_pkg::STATUS_OK));
        add_ev(mk_ev(uart_rb_pkg::ACT_TX_DONE,   8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00), 1'b1, none);
        // Distinct substitution codes, plus a write to the unused index
        add_reg(uart_rb_pkg::CFG_FRAMING, 8'hA5);
        add_reg(uart_rb_pkg::CFG_BREAK,   8'h5A);
        add_reg(uart_rb_pkg::CFG_OVERRUN, 8'hC3);
        add_reg(CFG_UNUSED,               8'hFF);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, 8'h12, 1'b1, 1'b0, 1'b0, 8'h00), 1'b1, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, 8'h34, 1'b1, 1'b1, 1'b0, 8'h00), 1'b1, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, 8'h56, 1'b1, 1'b1, 1'b1, 8'h00), 1'b1, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_RECV, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
               mk_out(1'b0, 8'h00, 1'b1, 8'hFF, uart_rb_pkg::STATUS_OK));
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_RECV, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
               mk_out(1'b0, 8'h00, 1'b1, 8'h00, uart_rb_pkg::STATUS_OK));
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_RECV, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
               mk_out(1'b0, 8'h00, 1'b1, 8'hA5, uart_rb_pkg::STATUS_OK));
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_RECV, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
               mk_out(1'b0, 8'h00, 1'b1, 8'h5A, uart_rb_pkg::STATUS_OK));
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_RECV, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
               mk_out(1'b0, 8'h00, 1'b1, 8'hC3, uart_rb_pkg::STATUS_OK));
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_RECV, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
               mk_out(1'b0, 8'h00, 1'b0, 8'h00, uart_rb_pkg::STATUS_RX_EMPTY));
        // Handshake: XOFF halts, queued byte goes out on XON
        add_reg(uart_rb_pkg::CFG_HANDSHAKE, 8'h01);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, uart_rb_pkg::XOFF_RST,
                     1'b0, 1'b0, 1'b0, 8'h00), 1'b1, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_SEND, 8'h00, 1'b0, 1'b0, 1'b0, 8'h42), 1'b1, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, uart_rb_pkg::XON_RST,
                     1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
               mk_out(1'b1, 8'h42, 1'b0, 8'h00, uart_rb_pkg::STATUS_OK));
        // Top threshold sends XOFF early; substituted byte acts as XOFF
        add_reg(uart_rb_pkg::CFG_THRESHOLD, 8'd63);
        add_reg(uart_rb_pkg::CFG_OVERRUN,   uart_rb_pkg::XOFF_RST);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, 8'h55, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, 8'h66, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_LINE_BYTE, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00), 1'b0, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_HOST_RECV, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0, none);
        add_ev(mk_ev(uart_rb_pkg::ACT_TX_DONE,   8'h00, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0, none);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the script
        in_reg_run = 1'b0;
        foreach (script[i]) begin
            if (script[i].is_reg) begin
                if (!in_reg_run) settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
                in_reg_run = 1'b1;
            end else begin
                if (in_reg_run) i_cfg_we <= 1'b0;
                in_reg_run = 1'b0;
                drive_item(script[i].ev, script[i].has_want, script[i].want);
            end
        end

        // Random phases, each under fresh register values
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            hs  = (ph == 0 || ph == 2) ? 1'b0 :
                  (ph == 1 || ph == 5) ? 1'b1 : 1'($urandom_range(0, 1));
            thr = (ph == 0) ? 6'd0 : (ph == 1) ? 6'd63 :
                  (ph == 3) ? 6'd1 : 6'($urandom_range(0, 63));
            foreach (codes[j]) begin
                codes[j] = (ph == 4) ? 8'h00 : (ph == 6) ? 8'hFF :
                           8'($urandom_range(0, 255));
            end
            write_reg(uart_rb_pkg::CFG_HANDSHAKE, {7'd0, hs});
            write_reg(uart_rb_pkg::CFG_THRESHOLD, {2'd0, thr});
            write_reg(uart_rb_pkg::CFG_XON,       codes[0]);
            write_reg(uart_rb_pkg::CFG_XOFF,      codes[1]);
            write_reg(uart_rb_pkg::CFG_FRAMING,   codes[2]);
            write_reg(uart_rb_pkg::CFG_BREAK,     codes[3]);
            write_reg(uart_rb_pkg::CFG_OVERRUN,   codes[4]);
            i_cfg_we <= 1'b0;

            // Open with a long shaped burst, then shorter random segments
            done = 0;
            while (done < PHASE_ITEMS) begin
                seg_mix = (done == 0) ? t_mix'(ph % 5) : t_mix'($urandom_range(0, 4));
                seg_len = (done == 0) ? 90 : $urandom_range(10, 40);
                calm    = ($urandom_range(0, 4) == 0);
                repeat (seg_len) drive_item(pick_event(seg_mix), 1'b0, none);
                done += seg_len;
            end
            calm = 1'b0;
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && ring_replies.size() == 0) begin
            $display("uart_ring_buffers_xon_xoff_unit verification clean");
        end else begin
            $display("uart_ring_buffers_xon_xoff_unit verification failed");
        end
        $finish;
    end

endmodule
